>>> sv/dts_pkg.sv
// dts_pkg: shared constants, register codes and word types of the delimiter trim stream
// no dependencies; compile first

package dts_pkg;

  // run buffer and delimiter set sizes
  localparam int MAX_RUN    = 32;
  localparam int MAX_DELIMS = 8;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int DBYTES_W   = 64;
  localparam int NUM_DBYTES = DBYTES_W / BYTE_W;
  localparam int DCOUNT_W   = 4;
  localparam int KEEP_W     = 6;
  localparam int OPT_W      = 4;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // run buffer addressing and run length counter (holds 0 .. MAX_RUN + 1)
  localparam int ADDR_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int RUN_W  = $clog2(MAX_RUN + 2);
  localparam int CMP_W  = (RUN_W > KEEP_W) ? RUN_W : KEEP_W;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // option bit positions in trim_options
  localparam int OPT_LEAD  = 0;
  localparam int OPT_TRAIL = 1;
  localparam int OPT_INBET = 2;
  localparam int OPT_SUBST = 3;

  // whitespace set: space and tab through carriage return
  localparam logic [BYTE_W-1:0] WS_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] WS_LO    = 8'd9;
  localparam logic [BYTE_W-1:0] WS_HI    = 8'd13;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIM_BYTES  = 2'd0,
    CFG_DELIM_COUNT  = 2'd1,
    CFG_KEEP_COUNT   = 2'd2,
    CFG_TRIM_OPTIONS = 2'd3
  } cfg_idx_e;

  // one command from front to back: buffer read burst, then an optional tail word
  typedef struct packed {
    logic [ADDR_W-1:0] rd_start;
    logic [RUN_W-1:0]  rd_count;
    logic              subst;
    logic [BYTE_W-1:0] subst_byte;
    logic              has_byte;
    logic [BYTE_W-1:0] char_byte;
    logic              last;
    logic              ovf;
    logic [CNT_W-1:0]  bytes_in;
    logic [CNT_W-1:0]  bytes_out;
  } cmd_t;

  // run buffer write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

endpackage

>>> sv/dts_in_if.sv
// dts_in_if: input byte channel (valid/ready with byte and end flag)
// depends on dts_pkg

interface dts_in_if import dts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] char_byte;
  logic              last_char;

  modport source (output valid, char_byte, last_char, input ready);
  modport sink   (input valid, char_byte, last_char, output ready);
endinterface

>>> sv/dts_out_if.sv
// dts_out_if: result channel (valid/ready with emitted byte and string end status)
// depends on dts_pkg

interface dts_out_if import dts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              run_last;
  logic              string_end;
  logic [CNT_W-1:0]  removed_count;
  logic              overflow;

  modport source (output valid, out_byte, byte_valid, run_last, string_end, removed_count,
                  overflow, input ready);
  modport sink   (input valid, out_byte, byte_valid, run_last, string_end, removed_count,
                  overflow, output ready);
endinterface

>>> sv/dts_cfg_if.sv
// dts_cfg_if: configuration write channel (valid/ready with register index and data)
// depends on dts_pkg

interface dts_cfg_if import dts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/dts_ram.sv
// dts_ram: generic single write, single read RAM with registered read data
// no dependencies

module dts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/dts_queue.sv
// dts_queue: short command queue between the classifying front and the emitting back
// depends on dts_pkg

module dts_queue import dts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> sv/dts_front.sv
// dts_front: configuration registers, delimiter classification, run tracking and
// command generation; depends on dts_pkg and the dts_in_if / dts_cfg_if interfaces

module dts_front import dts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  dts_in_if.sink  in_i,
  dts_cfg_if.sink cfg_i,
  output cmd_t    cmd_o,
  output logic    push_o,
  input  logic    q_full_i,
  input  logic    rd_done_i,
  output ram_wr_t ram_wr_o
);

  // configuration registers
  logic [DBYTES_W-1:0] delim_bytes_q;
  logic [DCOUNT_W-1:0] delim_count_q;
  logic [KEEP_W-1:0]   keep_count_q;
  logic [OPT_W-1:0]    trim_options_q;

  // per-string state
  logic [RUN_W-1:0] run_len_q, run_len_d;
  logic             in_middle_q, in_middle_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] bytes_in_q, bytes_in_d;
  logic [CNT_W-1:0] bytes_out_q, bytes_out_d;
  logic             pend_q, pend_d;

  // classification
  logic [DCOUNT_W-1:0]   n_clamp;
  logic [NUM_DBYTES-1:0] dmask;
  logic [NUM_DBYTES-1:0] dmatch;
  logic                  chain_ok;
  logic                  use_ws;
  logic [BYTE_W-1:0]     first_delim;
  logic                  is_delim;
  logic [BYTE_W-1:0]     b;
  logic                  last;
  logic                  acc;

  // release decision
  logic             rel_do, rel_en, rel_from_end, dump, has_byte;
  logic [RUN_W-1:0] rel_len;
  logic [CMP_W-1:0] keep_ext, len_ext, keep_k;
  logic [RUN_W-1:0] rd_count;
  logic [RUN_W-1:0] rd_start_full;
  logic             subst;
  logic [RUN_W-1:0] total;
  logic [CNT_W:0]   out_sum;
  logic [CNT_W-1:0] in_next, out_next;

  assign b     = in_i.char_byte;
  assign last  = in_i.last_char;
  assign in_i.ready  = !pend_q && !q_full_i;
  assign acc   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_bytes_q  <= '0;
      delim_count_q  <= '0;
      keep_count_q   <= '0;
      trim_options_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_DELIM_BYTES:  delim_bytes_q  <= cfg_i.data;
        CFG_DELIM_COUNT:  delim_count_q  <= cfg_i.data[DCOUNT_W-1:0];
        CFG_KEEP_COUNT:   keep_count_q   <= cfg_i.data[KEEP_W-1:0];
        CFG_TRIM_OPTIONS: trim_options_q <= cfg_i.data[OPT_W-1:0];
        default: ;
      endcase
    end
  end

  // active delimiter set: clamped count, cut at the first zero byte
  always_comb begin
    n_clamp  = (delim_count_q > DCOUNT_W'(MAX_DELIMS)) ? DCOUNT_W'(MAX_DELIMS) : delim_count_q;
    chain_ok = 1'b1;
    for (int i = 0; i < NUM_DBYTES; i++) begin
      chain_ok  = chain_ok && (delim_bytes_q[i*BYTE_W +: BYTE_W] != '0) &&
                  (DCOUNT_W'(i) < n_clamp);
      dmask[i]  = chain_ok;
      dmatch[i] = (delim_bytes_q[i*BYTE_W +: BYTE_W] == b);
    end
    use_ws      = !dmask[0];
    first_delim = use_ws ? WS_SPACE : delim_bytes_q[BYTE_W-1:0];
    is_delim    = use_ws ? ((b == WS_SPACE) || ((b >= WS_LO) && (b <= WS_HI)))
                         : |(dmask & dmatch);
  end

  // run tracking and release decision
  always_comb begin
    run_len_d    = run_len_q;
    in_middle_d  = in_middle_q;
    ovf_d        = ovf_q;
    rel_do       = 1'b0;
    rel_en       = 1'b0;
    rel_from_end = 1'b0;
    rel_len      = run_len_q;
    dump         = 1'b0;
    has_byte     = 1'b0;
    ram_wr_o.en   = 1'b0;
    ram_wr_o.addr = run_len_q[ADDR_W-1:0];
    ram_wr_o.data = b;
    if (is_delim) begin
      if (run_len_q > RUN_W'(MAX_RUN)) begin
        has_byte = 1'b1;
      end else if (run_len_q == RUN_W'(MAX_RUN)) begin
        // buffer overrun: dump the held run and this byte untouched
        dump      = 1'b1;
        has_byte  = 1'b1;
        run_len_d = RUN_W'(MAX_RUN + 1);
        ovf_d     = 1'b1;
      end else begin
        ram_wr_o.en = acc;
        run_len_d   = run_len_q + 1'b1;
      end
      if (last && (run_len_d <= RUN_W'(MAX_RUN))) begin
        rel_do       = 1'b1;
        rel_len      = run_len_d;
        rel_en       = in_middle_q ? trim_options_q[OPT_TRAIL] : trim_options_q[OPT_LEAD];
        rel_from_end = !in_middle_q;
      end
    end else begin
      if (run_len_q <= RUN_W'(MAX_RUN)) begin
        rel_do       = 1'b1;
        rel_en       = in_middle_q ? trim_options_q[OPT_INBET] : trim_options_q[OPT_LEAD];
        rel_from_end = !in_middle_q;
      end
      has_byte    = 1'b1;
      run_len_d   = '0;
      in_middle_d = 1'b1;
    end
  end

  // read burst for the run buffer
  always_comb begin
    keep_ext      = CMP_W'(keep_count_q);
    len_ext       = CMP_W'(rel_len);
    keep_k        = (keep_ext < len_ext) ? keep_ext : len_ext;
    rd_count      = '0;
    rd_start_full = '0;
    subst         = 1'b0;
    if (dump) begin
      rd_count = RUN_W'(MAX_RUN);
    end else if (rel_do) begin
      if (!rel_en) begin
        rd_count = rel_len;
      end else begin
        rd_count      = keep_k[RUN_W-1:0];
        rd_start_full = rel_from_end ? rel_len - keep_k[RUN_W-1:0] : '0;
        subst         = trim_options_q[OPT_SUBST];
      end
    end
  end

  // saturating byte counters
  always_comb begin
    total    = rd_count + RUN_W'(has_byte);
    in_next  = (bytes_in_q == '1) ? bytes_in_q : bytes_in_q + 1'b1;
    out_sum  = {1'b0, bytes_out_q} + (CNT_W + 1)'(total);
    out_next = out_sum[CNT_W] ? '1 : out_sum[CNT_W-1:0];
    bytes_in_d  = last ? '0 : in_next;
    bytes_out_d = last ? '0 : out_next;
  end

  // command word to the back
  always_comb begin
    cmd_o.rd_start   = rd_start_full[ADDR_W-1:0];
    cmd_o.rd_count   = rd_count;
    cmd_o.subst      = subst;
    cmd_o.subst_byte = first_delim;
    cmd_o.has_byte   = has_byte;
    cmd_o.char_byte  = b;
    cmd_o.last       = last;
    cmd_o.ovf        = ovf_d;
    cmd_o.bytes_in   = in_next;
    cmd_o.bytes_out  = out_next;
    push_o = acc && ((rd_count != '0) || has_byte || last);
    pend_d = pend_q;
    if (push_o && (rd_count != '0)) begin
      pend_d = 1'b1;
    end else if (rd_done_i) begin
      pend_d = 1'b0;
    end
  end

  // string state, cleared at string end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q   <= '0;
      in_middle_q <= 1'b0;
      ovf_q       <= 1'b0;
      bytes_in_q  <= '0;
      bytes_out_q <= '0;
      pend_q      <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (acc) begin
        run_len_q   <= last ? '0 : run_len_d;
        in_middle_q <= last ? 1'b0 : in_middle_d;
        ovf_q       <= last ? 1'b0 : ovf_d;
        bytes_in_q  <= bytes_in_d;
        bytes_out_q <= bytes_out_d;
      end
    end
  end

endmodule

>>> sv/dts_back.sv
// dts_back: executes queued commands, streams buffered run bytes and the tail word
// into the output register; depends on dts_pkg and dts_out_if

module dts_back import dts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              head_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  output logic [ADDR_W-1:0] rd_addr_o,
  input  logic [BYTE_W-1:0] rd_data_i,
  output logic              rd_done_o,
  dts_out_if.source         out_o
);

  cmd_t              cur_q;
  logic              cur_valid_q, cur_valid_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [RUN_W-1:0]  rem_q, rem_d;
  logic              out_valid_q, out_valid_d;

  logic              can_load, tail, step, step_read, final_step;
  logic [BYTE_W-1:0] word_byte;
  logic              word_valid;
  logic [CNT_W:0]    diff;
  logic [CNT_W-1:0]  removed;

  // step control: one word per cycle when the output register is free
  always_comb begin
    can_load   = !out_valid_q || out_o.ready;
    tail       = cur_q.has_byte || (cur_q.rd_count == '0);
    step       = cur_valid_q && can_load;
    step_read  = step && (rem_q != '0);
    final_step = step && ((rem_q == '0) || ((rem_q == RUN_W'(1)) && !tail));
    pop_o      = !q_empty_i && (!cur_valid_q || final_step);
    rd_done_o  = step_read && (rem_q == RUN_W'(1));

    idx_d       = idx_q;
    rem_d       = rem_q;
    cur_valid_d = cur_valid_q;
    if (pop_o) begin
      idx_d       = head_i.rd_start;
      rem_d       = head_i.rd_count;
      cur_valid_d = 1'b1;
    end else begin
      if (step_read) begin
        idx_d = idx_q + 1'b1;
        rem_d = rem_q - 1'b1;
      end
      if (final_step) begin
        cur_valid_d = 1'b0;
      end
    end
    // read address runs one ahead so read data lines up with idx_q
    rd_addr_o = idx_d;

    out_valid_d = step ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  // word contents
  always_comb begin
    if (step_read) begin
      word_byte  = cur_q.subst ? cur_q.subst_byte : rd_data_i;
      word_valid = 1'b1;
    end else begin
      word_byte  = cur_q.has_byte ? cur_q.char_byte : '0;
      word_valid = cur_q.has_byte;
    end
    diff    = {1'b0, cur_q.bytes_in} - {1'b0, cur_q.bytes_out};
    removed = diff[CNT_W] ? '0 : diff[CNT_W-1:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      rem_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      rem_q       <= rem_d;
    end
  end

  // command and output payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (step) begin
      out_o.out_byte      <= word_byte;
      out_o.byte_valid    <= word_valid;
      out_o.run_last      <= final_step;
      out_o.string_end    <= final_step && cur_q.last;
      out_o.removed_count <= (final_step && cur_q.last) ? removed : '0;
      out_o.overflow      <= final_step && cur_q.last && cur_q.ovf;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

>>> sv/delimiter_trim_stream_core.sv
// delimiter_trim_stream_core: top level of the delimiter trim and collapse stream
// depends on dts_pkg, the channel interfaces, dts_front, dts_queue, dts_back, dts_ram
//
// Usage:
//   in_i carries one string byte per word with last_char marking the string end.
//   out_o carries the kept bytes; the word that closes a string has string_end set
//   with removed_count and overflow, and run_last marks the last word caused by
//   one input word. cfg_i writes delim_bytes, delim_count, keep_count and
//   trim_options (indexes 0 to 3); it is always ready; the user writes it only while
//   idle, which the block does not enforce. A directly emitted byte passes the
//   command queue, the command register and the output register on its way to out_o.
//   Throughput: one input word per cycle while no held run is released and out_o
//   does not stall; a released run leaves at one word per cycle while out_o takes
//   words, and in_i is held off after the word that starts the release until the
//   single read port has read the run out of the run buffer. The output is one word per cycle at best.
//   Reset clears all string state and configuration; the run buffer needs no clearing.
//   When out_o stalls the output register holds its word; the two-entry command
//   queue keeps taking input until it fills, then in_i ready drops.

module delimiter_trim_stream_core import dts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dts_in_if.sink    in_i,
  dts_out_if.source out_o,
  dts_cfg_if.sink   cfg_i
);

  cmd_t              cmd, head;
  logic              push, pop, q_full, q_empty;
  logic              rd_done;
  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  // classify bytes and decide releases
  dts_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .cmd_o     (cmd),
    .push_o    (push),
    .q_full_i  (q_full),
    .rd_done_i (rd_done),
    .ram_wr_o  (ram_wr)
  );

  // decoupling queue
  dts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty)
  );

  // held delimiter run buffer
  dts_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_RUN)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // emit words
  dts_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .rd_done_o (rd_done),
    .out_o     (out_o)
  );

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for delimiter_trim_stream_core
// depends on dts_pkg, dts_in_if, dts_out_if, dts_cfg_if and the core rtl
// directed stimulus table first, then random strings under several register settings

module testbench;
  import dts_pkg::*;

  localparam int NUM_PHASES    = 8;
  localparam int PHASE_CHARS   = 15;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 3000;

  // one result word as seen on out_o
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              string_end;
    logic [CNT_W-1:0]  removed_count;
    logic              overflow;
  } out_word_t;

  // one full register setting
  typedef struct packed {
    logic [DBYTES_W-1:0] dbytes;
    logic [DCOUNT_W-1:0] dcount;
    logic [KEEP_W-1:0]   keep;
    logic [OPT_W-1:0]    opts;
  } cfg_set_t;

  // directed row: optional setting to load first, the byte, and a typed-in word
  typedef struct packed {
    logic [2:0]        preset;
    logic [BYTE_W-1:0] ch;
    logic              last;
    logic              typed;
    out_word_t         word;
  } trim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dts_in_if  in_if ();
  dts_out_if out_if ();
  dts_cfg_if cfg_if ();

  delimiter_trim_stream_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // directed settings; entry 0 stands for the reset values
  cfg_set_t dir_presets [5] = '{
    '0,
    '{64'h5F2D, 4'd2, 6'd1, 4'hF},
    '{64'h2C, 4'd15, 6'd0, 4'h3},
    '{64'hFEFD_FCFB_FAF9_F8FF, 4'd8, 6'd32, 4'h7},
    '{64'h2C00, 4'd3, 6'd2, 4'hD}
  };

  trim_row_t dir_rows [28] = '{
    // reset setting: whitespace set, nothing trimmed
    '{3'd0, 8'h61, 1'b1, 1'b1, '{8'h61, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0}},
    '{3'd0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0}},
    '{3'd0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0}},
    '{3'd0, 8'h20, 1'b0, 1'b0, '0},
    '{3'd0, 8'h62, 1'b0, 1'b0, '0},
    '{3'd0, 8'h09, 1'b1, 1'b0, '0},
    // dash and underscore, keep one, all rules plus substitution
    '{3'd1, 8'h2D, 1'b0, 1'b0, '0},
    '{3'd0, 8'h2D, 1'b0, 1'b0, '0},
    '{3'd0, 8'h78, 1'b0, 1'b0, '0},
    '{3'd0, 8'h5F, 1'b0, 1'b0, '0},
    '{3'd0, 8'h5F, 1'b0, 1'b0, '0},
    '{3'd0, 8'h79, 1'b0, 1'b0, '0},
    '{3'd0, 8'h2D, 1'b0, 1'b0, '0},
    '{3'd0, 8'h2D, 1'b1, 1'b0, '0},
    // count above range, set cut at a zero byte, keep none: empty closing words
    '{3'd2, 8'h2C, 1'b0, 1'b0, '0},
    '{3'd0, 8'h7A, 1'b0, 1'b0, '0},
    '{3'd0, 8'h2C, 1'b0, 1'b0, '0},
    '{3'd0, 8'h2C, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 32'd3, 1'b0}},
    '{3'd0, 8'h2C, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 32'd1, 1'b0}},
    // eight high delimiters, keep at maximum
    '{3'd3, 8'hFF, 1'b0, 1'b0, '0},
    '{3'd0, 8'h01, 1'b0, 1'b0, '0},
    '{3'd0, 8'hF8, 1'b0, 1'b0, '0},
    '{3'd0, 8'hFE, 1'b1, 1'b0, '0},
    // zero first byte falls back to whitespace, trailing rule off
    '{3'd4, 8'h0D, 1'b0, 1'b0, '0},
    '{3'd0, 8'h20, 1'b0, 1'b0, '0},
    '{3'd0, 8'h0B, 1'b0, 1'b0, '0},
    '{3'd0, 8'h71, 1'b0, 1'b0, '0},
    '{3'd0, 8'h0A, 1'b1, 1'b0, '0}
  };

  // predictor copy of the registers
  logic [DBYTES_W-1:0] cfg_delim_bytes = '0;
  logic [DCOUNT_W-1:0] cfg_delim_count = '0;
  logic [KEEP_W-1:0]   cfg_keep = '0;
  logic [OPT_W-1:0]    cfg_opts = '0;

  // predictor copy of the string state
  bit                trim_mid = 1'b0;
  int unsigned       held_len = 0;
  logic [BYTE_W-1:0] held_run [MAX_RUN];
  logic [CNT_W-1:0]  str_bytes_in = '0;
  logic [CNT_W-1:0]  str_bytes_out = '0;
  bit                str_overflowed = 1'b0;

  out_word_t step_q[$];
  out_word_t exp_words_q[$];

  int err_cnt = 0;
  int chars_sent = 0;
  int strings_sent = 0;
  int words_seen = 0;
  int ovf_strings = 0;
  int stall_cnt = 0;
  int ready_left = 0;
  bit quiet_tail = 1'b0;

  // delimiter set lookup
  function automatic logic [BYTE_W-1:0] delim_at(int unsigned i);
    return cfg_delim_bytes[i*BYTE_W +: BYTE_W];
  endfunction

  function automatic int unsigned active_delims();
    int unsigned n;
    int unsigned e;
    n = (cfg_delim_count > MAX_DELIMS) ? MAX_DELIMS : cfg_delim_count;
    e = 0;
    while (e < n && delim_at(e) != 8'd0) e++;
    return e;
  endfunction

  function automatic bit is_delimiter(logic [BYTE_W-1:0] b);
    int unsigned e;
    e = active_delims();
    if (e == 0) return (b == WS_SPACE) || (b >= WS_LO && b <= WS_HI);
    for (int unsigned i = 0; i < e; i++) if (delim_at(i) == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [BYTE_W-1:0] lead_delim();
    return (active_delims() == 0) ? WS_SPACE : delim_at(0);
  endfunction

  // append one word to this step's results, counting emitted bytes
  function automatic void put_word(logic [BYTE_W-1:0] b, logic v);
    out_word_t w;
    w = '0;
    w.out_byte = v ? b : 8'd0;
    w.byte_valid = v;
    step_q.push_back(w);
    if (v && str_bytes_out != '1) str_bytes_out++;
  endfunction

  // release the held run: whole if its rule is off, else keep_count from head or tail
  function automatic void flush_run(bit trim_on, bit keep_tail);
    int unsigned len;
    int unsigned k;
    int unsigned start;
    len = (held_len > MAX_RUN) ? MAX_RUN : held_len;
    if (!trim_on) begin
      for (int unsigned i = 0; i < len; i++) put_word(held_run[i], 1'b1);
      return;
    end
    k = (cfg_keep < len) ? cfg_keep : len;
    start = keep_tail ? len - k : 0;
    for (int unsigned i = start; i < start + k; i++)
      put_word(cfg_opts[OPT_SUBST] ? lead_delim() : held_run[i], 1'b1);
  endfunction

  // expected words for one accepted input byte, left in step_q
  function automatic void predict_trim(logic [BYTE_W-1:0] b, logic last);
    step_q.delete();
    if (str_bytes_in != '1) str_bytes_in++;
    if (is_delimiter(b)) begin
      if (held_len > MAX_RUN) begin
        put_word(b, 1'b1);
      end else if (held_len == MAX_RUN) begin
        // buffer overrun: everything held goes out untouched
        for (int unsigned i = 0; i < MAX_RUN; i++) put_word(held_run[i], 1'b1);
        put_word(b, 1'b1);
        held_len = MAX_RUN + 1;
        str_overflowed = 1'b1;
      end else begin
        held_run[held_len] = b;
        held_len++;
      end
      if (last && held_len <= MAX_RUN) begin
        if (trim_mid) flush_run(cfg_opts[OPT_TRAIL], 1'b0);
        else flush_run(cfg_opts[OPT_LEAD], 1'b1);
      end
    end else begin
      if (held_len <= MAX_RUN) begin
        if (trim_mid) flush_run(cfg_opts[OPT_INBET], 1'b0);
        else flush_run(cfg_opts[OPT_LEAD], 1'b1);
      end
      held_len = 0;
      put_word(b, 1'b1);
      trim_mid = 1'b1;
    end
    if (last) begin
      if (step_q.size() == 0) put_word(8'd0, 1'b0);
      step_q[step_q.size()-1].string_end = 1'b1;
      step_q[step_q.size()-1].removed_count =
        (str_bytes_in >= str_bytes_out) ? str_bytes_in - str_bytes_out : '0;
      step_q[step_q.size()-1].overflow = str_overflowed;
      trim_mid = 1'b0;
      held_len = 0;
      str_bytes_in = '0;
      str_bytes_out = '0;
      str_overflowed = 1'b0;
    end
    if (step_q.size() != 0) step_q[step_q.size()-1].run_last = 1'b1;
  endfunction

  // field by field comparison of one result word
  task automatic check_word(out_word_t exp_w, out_word_t got_w);
    if (got_w.out_byte !== exp_w.out_byte) begin
      $error("out_byte: expected %0h, got %0h", exp_w.out_byte, got_w.out_byte);
      err_cnt++;
    end
    if (got_w.byte_valid !== exp_w.byte_valid) begin
      $error("byte_valid: expected %0b, got %0b", exp_w.byte_valid, got_w.byte_valid);
      err_cnt++;
    end
    if (got_w.run_last !== exp_w.run_last) begin
      $error("run_last: expected %0b, got %0b", exp_w.run_last, got_w.run_last);
      err_cnt++;
    end
    if (got_w.string_end !== exp_w.string_end) begin
      $error("string_end: expected %0b, got %0b", exp_w.string_end, got_w.string_end);
      err_cnt++;
    end
    if (got_w.removed_count !== exp_w.removed_count) begin
      $error("removed_count: expected %0d, got %0d", exp_w.removed_count,
             got_w.removed_count);
      err_cnt++;
    end
    if (got_w.overflow !== exp_w.overflow) begin
      $error("overflow: expected %0b, got %0b", exp_w.overflow, got_w.overflow);
      err_cnt++;
    end
  endtask

  // drive one input word, with an occasional gap burst before it
  task automatic send_char(logic [BYTE_W-1:0] b, logic last, logic typed,
                           out_word_t typed_word);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_byte <= b;
    in_if.last_char <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_trim(b, last);
    if (typed) exp_words_q.push_back(typed_word);
    else foreach (step_q[i]) exp_words_q.push_back(step_q[i]);
    chars_sent++;
    if (last) strings_sent++;
  endtask

  // one register write; valid is left high for the next write
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_DELIM_BYTES:  cfg_delim_bytes = val;
      CFG_DELIM_COUNT:  cfg_delim_count = val[DCOUNT_W-1:0];
      CFG_KEEP_COUNT:   cfg_keep = val[KEEP_W-1:0];
      CFG_TRIM_OPTIONS: cfg_opts = val[OPT_W-1:0];
      default: ;
    endcase
  endtask

  // wait for the block to drain, then load all four registers
  task automatic apply_config(cfg_set_t c);
    in_if.valid <= 1'b0;
    while (exp_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_DELIM_BYTES, c.dbytes);
    write_reg(CFG_DELIM_COUNT, CFG_DATA_W'(c.dcount));
    write_reg(CFG_KEEP_COUNT, CFG_DATA_W'(c.keep));
    write_reg(CFG_TRIM_OPTIONS, CFG_DATA_W'(c.opts));
    cfg_if.valid <= 1'b0;
  endtask

  // random setting per phase; early phases pin the extremes
  function automatic cfg_set_t pick_config(int ph);
    cfg_set_t c;
    c.dbytes = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) c.dbytes[$urandom_range(0, 7)*BYTE_W +: BYTE_W] = 8'd0;
    c.dcount = DCOUNT_W'($urandom_range(0, 15));
    c.keep   = ($urandom_range(0, 3) == 0) ? KEEP_W'($urandom_range(0, 32)) :
                                             KEEP_W'($urandom_range(0, 3));
    c.opts   = OPT_W'($urandom_range(0, 15));
    case (ph)
      0: c = '{'1, 4'd15, 6'd32, 4'hF};
      1: c = '0;
      2: begin
        c.dcount = 4'd1;
        c.opts   = 4'hF;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_delim();
    int unsigned e;
    int unsigned v;
    e = active_delims();
    if (e == 0) begin
      v = $urandom_range(8, 13);
      return (v == 8) ? WS_SPACE : BYTE_W'(v);
    end
    return delim_at($urandom_range(0, e - 1));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_plain();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(1, 255)); while (is_delimiter(b));
    return b;
  endfunction

  // mostly short runs, some medium, a few near or past the buffer size
  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 3);
    if (r < 18) return $urandom_range(4, 8);
    return $urandom_range(30, 36);
  endfunction

  // well-formed string: leading run, words split by runs, trailing run
  // long_sel forces a long leading (1), interior (2) or trailing (3) run
  task automatic send_string(int long_sel);
    logic [BYTE_W-1:0] str_q[$];
    int nwords;
    int run;
    nwords = (long_sel == 2) ? 2 + $urandom_range(0, 1) : $urandom_range(0, 3);
    run = (long_sel == 1) ? MAX_RUN + 1 : pick_run();
    if (nwords == 0 && run == 0) run = 1;
    repeat (run) str_q.push_back(pick_delim());
    for (int w = 0; w < nwords; w++) begin
      repeat ($urandom_range(1, 4)) str_q.push_back(pick_plain());
      if (w < nwords - 1) begin
        run = (long_sel == 2 && w == 0) ? MAX_RUN + 2 : pick_run();
        if (run == 0) run = 1;
        repeat (run) str_q.push_back(pick_delim());
      end
    end
    run = (long_sel == 3) ? MAX_RUN + 8 : pick_run();
    repeat (run) str_q.push_back(pick_delim());
    // noise: one arbitrary byte dropped in
    if ($urandom_range(0, 9) == 0)
      str_q[$urandom_range(0, str_q.size() - 1)] = BYTE_W'($urandom_range(0, 255));
    foreach (str_q[i]) send_char(str_q[i], i == str_q.size() - 1, 1'b0, '0);
  endtask

  // receiver: random stall bursts and ready stretches, always ready at the tail
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      ready_left   <= 0;
    end else if (quiet_tail) begin
      out_if.ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      out_if.ready <= 1'b1;
      ready_left   <= $urandom_range(1, 40);
    end else begin
      out_if.ready <= 1'b0;
      ready_left   <= $urandom_range(1, 18);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_seen++;
      if (out_if.string_end && out_if.overflow) ovf_strings++;
      if (exp_words_q.size() == 0) begin
        $error("unexpected word: out_byte %0h string_end %0b", out_if.out_byte,
               out_if.string_end);
        err_cnt++;
      end else begin
        check_word(exp_words_q.pop_front(),
                   '{out_if.out_byte, out_if.byte_valid, out_if.run_last,
                     out_if.string_end, out_if.removed_count, out_if.overflow});
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // main sequence
  initial begin
    int phase_start;
    in_if.valid     <= 1'b0;
    in_if.char_byte <= '0;
    in_if.last_char <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_DELIM_BYTES;
    cfg_if.data     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].preset != 0) apply_config(dir_presets[dir_rows[i].preset]);
      send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].word);
    end

    // random phases, each under its own setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      apply_config(pick_config(ph));
      quiet_tail  = (ph == NUM_PHASES - 1);
      phase_start = chars_sent;
      send_string((ph >= 1 && ph <= 3) ? ph : 0);
      while (chars_sent - phase_start < PHASE_CHARS) send_string(0);
    end
    in_if.valid <= 1'b0;

    // drain
    while (exp_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d strings, %0d bytes in, %0d words out", strings_sent,
             chars_sent, words_seen);
    $display("%0d register settings after the directed ones, %0d strings flagged overflow",
             NUM_PHASES, ovf_strings);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
